// ===== rtl/core/pls_pkg.sv =====
// ============================================================================
// pls_pkg
// Shared types, codes and constants of the pulse train generator.
// ============================================================================
package pls_pkg;

    // Field widths of the item ports.
    localparam int FREQ_W       = 26;
    localparam int PULSE_W      = 16;
    localparam int MAXP_W       = 16;
    localparam int REM_W        = 15;
    localparam int STATUS_W     = 2;
    localparam int SHIFT_W      = 3;
    localparam int PERIOD_OUT_W = 16;
    localparam int CMD_W        = 2;

    // Configuration port.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Parameter defaults.
    localparam int PRESCALE_STEPS_DEF = 8;
    localparam int COUNT_BITS_DEF     = 16;

    // Register reset values.
    localparam logic [FREQ_W-1:0] BUS_CLK_RST  = 26'd24000000;
    localparam logic [FREQ_W-1:0] SLOW_CLK_RST = 26'd785000;
    localparam logic [MAXP_W-1:0] MAX_PER_RST  = 16'd32767;

    localparam logic [REM_W-1:0] REM_SAT = {REM_W{1'b1}};

    typedef enum logic [1:0] {
        REG_BUS_CLK  = 2'd0,
        REG_SLOW_CLK = 2'd1,
        REG_MAX_PER  = 2'd2
    } t_reg_index;

    typedef enum logic [CMD_W-1:0] {
        CMD_START = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NOP   = 2'd3
    } t_command;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_ZERO  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE     = 2'd0,
        S_DIV_BUS  = 2'd1,
        S_DIV_SLOW = 2'd2,
        S_FINISH   = 2'd3
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec_item;
        logic div_start;
        logic div_src;
        logic apply;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic long_start;
        logic div_done;
        logic fit;
    } t_dp_status;

endpackage

// ===== rtl/core/pls_div.sv =====
// ============================================================================
// pls_div
// Iterative restoring divider, one quotient bit per cycle.
// ============================================================================
module pls_div #(
    parameter int W = pls_pkg::FREQ_W
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(W + 1);

    logic             r_busy;
    logic             n_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [W:0]       r_rem;
    logic [W:0]       n_rem;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     n_quo;
    logic [W-1:0]     r_div;
    logic [W-1:0]     n_div;
    logic [W:0]       rem_sh;

    assign rem_sh = {r_rem[W-1:0], r_quo[W-1]};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(W);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_div  = i_divisor;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end else begin
                n_cnt = r_cnt - 1'b1;
                if (rem_sh >= {1'b0, r_div}) begin
                    n_rem = rem_sh - {1'b0, r_div};
                    n_quo = {r_quo[W-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh;
                    n_quo = {r_quo[W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_done     = r_busy && (r_cnt == '0);
    assign o_quotient = r_quo;

endmodule

// ===== rtl/core/pls_datapath.sv =====
// ============================================================================
// pls_datapath
// Configuration registers, timer channel state, prescale search and
// the result register of the pulse train generator.
// ============================================================================
module pls_datapath #(
    parameter int PRESCALE_STEPS = pls_pkg::PRESCALE_STEPS_DEF,
    parameter int COUNT_BITS     = pls_pkg::COUNT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pls_pkg::t_dp_cmd                    i_cmd,
    output pls_pkg::t_dp_status                 o_status_dp,
    input  logic [pls_pkg::CMD_W-1:0]           i_command,
    input  logic [pls_pkg::FREQ_W-1:0]          i_frequency,
    input  logic signed [pls_pkg::PULSE_W-1:0]  i_pulses,
    input  logic                                i_bus_tick,
    input  logic                                i_slow_tick,
    input  logic                                i_cfg_write,
    input  logic [pls_pkg::APB_ADDR_W-1:0]      i_cfg_addr,
    input  logic [pls_pkg::APB_DATA_W-1:0]      i_cfg_wdata,
    output logic [pls_pkg::APB_DATA_W-1:0]      o_cfg_rdata,
    output logic                                o_pin_level,
    output logic [pls_pkg::REM_W-1:0]           o_remaining,
    output logic [pls_pkg::STATUS_W-1:0]        o_status,
    output logic [pls_pkg::SHIFT_W-1:0]         o_prescale_shift,
    output logic                                o_clock_source,
    output logic [pls_pkg::PERIOD_OUT_W-1:0]    o_period_minus_one,
    output logic                                o_match_event
);

    localparam int FW = pls_pkg::FREQ_W;
    localparam int MW = pls_pkg::MAXP_W;
    localparam int PLW = pls_pkg::PULSE_W;
    localparam int SW = pls_pkg::SHIFT_W;
    localparam int CW = COUNT_BITS;
    localparam int PW = (PRESCALE_STEPS > 1) ? PRESCALE_STEPS - 1 : 1;

    // Configuration registers.
    logic [FW-1:0] r_bus_clk;
    logic [FW-1:0] r_slow_clk;
    logic [MW-1:0] r_max_per;

    // Channel state.
    logic [CW-1:0]  r_count,   n_count;
    logic [PW-1:0]  r_presc,   n_presc;
    logic [SW-1:0]  r_shift,   n_shift;
    logic           r_src,     n_src;
    logic [CW-1:0]  r_period,  n_period;
    logic [CW-1:0]  r_compare, n_compare;
    logic           r_on,      n_on;
    logic           r_armed,   n_armed;
    logic [PLW-1:0] r_pl,      n_pl;

    // Start transaction operands and search results.
    logic [FW-1:0]         r_freq;
    logic signed [PLW-1:0] r_pulses;
    logic                  r_div_src;
    logic                  r_fit;
    logic [SW-1:0]         r_fit_shift;
    logic [MW-1:0]         r_fit_q;

    logic [FW-1:0] div_dividend;
    logic [FW-1:0] div_divisor;
    logic          div_done;
    logic [FW-1:0] div_quo;

    logic          fit;
    logic [SW-1:0] fit_shift;
    logic [FW-1:0] fit_q_full;

    logic [pls_pkg::STATUS_W-1:0] n_status;
    logic                         n_match;

    logic          edge_sel;
    logic [PW-1:0] presc_mask;
    logic [PW-1:0] presc_inc;
    logic [CW-1:0] cnt_adv;
    logic [PLW-1:0] pl_dec;
    logic [CW-1:0] start_period;

    assign div_dividend = i_cmd.div_src ? r_slow_clk : r_bus_clk;
    assign div_divisor  = i_cmd.div_src ? r_freq : i_frequency;

    pls_div #(
        .W (FW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // (clk >> s) / f equals (clk / f) >> s, so one quotient serves every shift.
    always_comb begin
        fit       = 1'b0;
        fit_shift = '0;
        for (int s = PRESCALE_STEPS - 1; s >= 0; s--) begin
            if ((div_quo >> s) <= FW'(r_max_per)) begin
                fit       = 1'b1;
                fit_shift = SW'(s);
            end
        end
    end

    assign fit_q_full = div_quo >> fit_shift;

    assign o_status_dp.long_start = (i_command == pls_pkg::CMD_START) && (i_frequency != '0);
    assign o_status_dp.div_done   = div_done;
    assign o_status_dp.fit        = fit;

    assign edge_sel  = r_src ? i_slow_tick : i_bus_tick;
    assign presc_inc = (r_presc + 1'b1) & presc_mask;
    assign cnt_adv   = (r_count == r_period) ? '0 : r_count + 1'b1;
    assign pl_dec    = (r_pl != '0) ? r_pl - 1'b1 : r_pl;
    // A zero quotient wraps to all ones within the counter width.
    assign start_period = CW'(r_fit_q) - 1'b1;

    always_comb begin
        for (int i = 0; i < PW; i++) begin
            presc_mask[i] = (i < int'(r_shift));
        end
    end

    always_comb begin
        n_count   = r_count;
        n_presc   = r_presc;
        n_shift   = r_shift;
        n_src     = r_src;
        n_period  = r_period;
        n_compare = r_compare;
        n_on      = r_on;
        n_armed   = r_armed;
        n_pl      = r_pl;
        n_status  = pls_pkg::STATUS_OK;
        n_match   = 1'b0;
        if (i_cmd.exec_item) begin
            case (i_command)
                pls_pkg::CMD_START: begin
                    n_status = pls_pkg::STATUS_ZERO;
                end
                pls_pkg::CMD_STOP: begin
                    n_compare = '0;
                end
                pls_pkg::CMD_TICK: begin
                    if (edge_sel) begin
                        n_presc = presc_inc;
                        if (presc_inc == '0) begin
                            n_count = cnt_adv;
                            if (r_on && (cnt_adv == r_compare)) begin
                                n_match = 1'b1;
                                if (r_armed) begin
                                    n_pl = pl_dec;
                                    if (pl_dec == '0) begin
                                        n_compare = '0;
                                        n_on      = 1'b0;
                                        n_armed   = 1'b0;
                                    end
                                end
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end else if (i_cmd.apply) begin
            if (r_fit) begin
                n_src     = r_div_src;
                n_shift   = r_fit_shift;
                n_period  = start_period;
                n_compare = start_period >> 1;
                n_count   = '0;
                n_presc   = '0;
                n_on      = 1'b1;
                if (!r_pulses[PLW-1] && (r_pulses != '0)) begin
                    n_pl    = $unsigned(r_pulses) + 1'b1;
                    n_armed = 1'b1;
                end else begin
                    n_armed = 1'b0;
                end
            end else begin
                n_src    = 1'b1;
                n_shift  = '0;
                n_status = pls_pkg::STATUS_RANGE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_clk  <= pls_pkg::BUS_CLK_RST;
            r_slow_clk <= pls_pkg::SLOW_CLK_RST;
            r_max_per  <= pls_pkg::MAX_PER_RST;
        end else if (i_cfg_write) begin
            case (i_cfg_addr[3:2])
                pls_pkg::REG_BUS_CLK:  r_bus_clk  <= i_cfg_wdata[FW-1:0];
                pls_pkg::REG_SLOW_CLK: r_slow_clk <= i_cfg_wdata[FW-1:0];
                pls_pkg::REG_MAX_PER:  r_max_per  <= i_cfg_wdata[MW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (i_cfg_addr[3:2])
            pls_pkg::REG_BUS_CLK:  o_cfg_rdata = pls_pkg::APB_DATA_W'(r_bus_clk);
            pls_pkg::REG_SLOW_CLK: o_cfg_rdata = pls_pkg::APB_DATA_W'(r_slow_clk);
            pls_pkg::REG_MAX_PER:  o_cfg_rdata = pls_pkg::APB_DATA_W'(r_max_per);
            default:               o_cfg_rdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_presc   <= '0;
            r_shift   <= '0;
            r_src     <= 1'b0;
            r_period  <= '0;
            r_compare <= '0;
            r_on      <= 1'b1;
            r_armed   <= 1'b0;
            r_pl      <= '0;
        end else begin
            r_count   <= n_count;
            r_presc   <= n_presc;
            r_shift   <= n_shift;
            r_src     <= n_src;
            r_period  <= n_period;
            r_compare <= n_compare;
            r_on      <= n_on;
            r_armed   <= n_armed;
            r_pl      <= n_pl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_div_src <= i_cmd.div_src;
        end
        if (i_cmd.div_start && !i_cmd.div_src) begin
            r_freq   <= i_frequency;
            r_pulses <= i_pulses;
        end
        if (div_done) begin
            r_fit       <= fit;
            r_fit_shift <= fit_shift;
            r_fit_q     <= MW'(fit_q_full);
        end
    end

    // Result register, loaded with the state as it stands after the transaction.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_pin_level        <= n_on && (n_count < n_compare);
            o_remaining        <= n_pl[PLW-1] ? pls_pkg::REM_SAT
                                              : n_pl[pls_pkg::REM_W-1:0];
            o_status           <= n_status;
            o_prescale_shift   <= n_shift;
            o_clock_source     <= n_src;
            o_period_minus_one <= pls_pkg::PERIOD_OUT_W'(n_period);
            o_match_event      <= n_match;
        end
    end

endmodule

// ===== rtl/core/pls_ctrl.sv =====
// ============================================================================
// pls_ctrl
// Controller of the pulse train generator: handshakes and start sequencing.
// ============================================================================
module pls_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  pls_pkg::t_dp_status i_status_dp,
    output pls_pkg::t_dp_cmd    o_cmd
);

    pls_pkg::t_state r_state;
    pls_pkg::t_state n_state;
    logic            r_out_valid;
    logic            out_free;
    logic            in_accept;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != pls_pkg::S_IDLE) || !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            pls_pkg::S_IDLE: begin
                if (in_accept && i_status_dp.long_start) begin
                    n_state = pls_pkg::S_DIV_BUS;
                end
            end
            pls_pkg::S_DIV_BUS: begin
                if (i_status_dp.div_done) begin
                    n_state = i_status_dp.fit ? pls_pkg::S_FINISH : pls_pkg::S_DIV_SLOW;
                end
            end
            pls_pkg::S_DIV_SLOW: begin
                if (i_status_dp.div_done) begin
                    n_state = pls_pkg::S_FINISH;
                end
            end
            pls_pkg::S_FINISH: begin
                if (out_free) begin
                    n_state = pls_pkg::S_IDLE;
                end
            end
            default: n_state = pls_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            pls_pkg::S_IDLE: begin
                if (in_accept) begin
                    if (i_status_dp.long_start) begin
                        o_cmd.div_start = 1'b1;
                    end else begin
                        o_cmd.exec_item = 1'b1;
                        o_cmd.out_load  = 1'b1;
                    end
                end
            end
            pls_pkg::S_DIV_BUS: begin
                // No shift fits on the bus clock: retry with the slow clock.
                if (i_status_dp.div_done && !i_status_dp.fit) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_src   = 1'b1;
                end
            end
            pls_pkg::S_FINISH: begin
                if (out_free) begin
                    o_cmd.apply    = 1'b1;
                    o_cmd.out_load = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pls_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/core/pulse_train_generator.sv =====
// ============================================================================
// pulse_train_generator
// Square-wave pulse train generator built like an edge-aligned PWM channel.
// ============================================================================
// Tick, stop and ignored items: result in the cycle after acceptance, one item per cycle
// while the output is not stalled. Start items run the serial divider on the bus clock and,
// when no shift fits there, again on the slow clock before the result is loaded.
// Zero-frequency starts answer like tick items. Synchronous active-low reset sets
// the channel state to its reset values and loads the configuration registers with their defaults.
module pulse_train_generator #(
    parameter int PRESCALE_STEPS = pls_pkg::PRESCALE_STEPS_DEF,
    parameter int COUNT_BITS     = pls_pkg::COUNT_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [pls_pkg::CMD_W-1:0]          i_command,
    input  logic [pls_pkg::FREQ_W-1:0]         i_frequency,
    input  logic signed [pls_pkg::PULSE_W-1:0] i_pulses,
    input  logic                               i_bus_tick,
    input  logic                               i_slow_tick,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_pin_level,
    output logic [pls_pkg::REM_W-1:0]          o_remaining,
    output logic [pls_pkg::STATUS_W-1:0]       o_status,
    output logic [pls_pkg::SHIFT_W-1:0]        o_prescale_shift,
    output logic                               o_clock_source,
    output logic [pls_pkg::PERIOD_OUT_W-1:0]   o_period_minus_one,
    output logic                               o_match_event,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pls_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [pls_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [pls_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    pls_pkg::t_dp_cmd    dp_cmd;
    pls_pkg::t_dp_status dp_status;
    logic                cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    pls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status_dp (dp_status),
        .o_cmd       (dp_cmd)
    );

    pls_datapath #(
        .PRESCALE_STEPS (PRESCALE_STEPS),
        .COUNT_BITS     (COUNT_BITS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (dp_cmd),
        .o_status_dp        (dp_status),
        .i_command          (i_command),
        .i_frequency        (i_frequency),
        .i_pulses           (i_pulses),
        .i_bus_tick         (i_bus_tick),
        .i_slow_tick        (i_slow_tick),
        .i_cfg_write        (cfg_write),
        .i_cfg_addr         (paddr),
        .i_cfg_wdata        (pwdata),
        .o_cfg_rdata        (prdata),
        .o_pin_level        (o_pin_level),
        .o_remaining        (o_remaining),
        .o_status           (o_status),
        .o_prescale_shift   (o_prescale_shift),
        .o_clock_source     (o_clock_source),
        .o_period_minus_one (o_period_minus_one),
        .o_match_event      (o_match_event)
    );

endmodule

// ===== rtl/core/pls_checker.sv =====
// ============================================================================
// pls_checker
// Port-level assertions of the pulse train generator, bound to the top level.
// ============================================================================
module pls_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_in_stall,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic [pls_pkg::STATUS_W-1:0]     o_status,
    input logic [pls_pkg::SHIFT_W-1:0]      o_prescale_shift,
    input logic                             o_clock_source,
    input logic [pls_pkg::PERIOD_OUT_W-1:0] o_period_minus_one,
    input logic                             o_match_event
);

    // A stalled transaction stays on the output unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_period_minus_one))
        else $error("stalled result changed or dropped");

    // With the single result register full and stalled, no new item may enter.
    a_in_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("input accepted while result register is blocked");

    // A compare match comes only from a tick, which never reports an error.
    a_match_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_match_event |-> o_status == pls_pkg::STATUS_OK)
        else $error("match reported together with an error status");

    // A failed search leaves the slow clock selected with no prescaling.
    a_range_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == pls_pkg::STATUS_RANGE
            |-> o_clock_source && o_prescale_shift == '0)
        else $error("range error without slow clock and shift zero");

endmodule

bind pulse_train_generator pls_checker u_pls_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_in_stall         (o_in_stall),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_status           (o_status),
    .o_prescale_shift   (o_prescale_shift),
    .o_clock_source     (o_clock_source),
    .o_period_minus_one (o_period_minus_one),
    .o_match_event      (o_match_event)
);
